@@ design/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  localparam int unsigned SpqDepth = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HeldW    = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [ValueW-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
`default_nettype none

// Sorted minimum priority queue holding up to DEPTH signed values, smallest at
// the front; among equal values the newest is taken first. One transaction is
// taken every clock cycle (busy_o never rises): every cell compares against the
// new value and shifts in parallel, so all cells update on the same clock
// edge. Its result appears on the next cycle, with result_valid_o high for
// exactly that one cycle; the receiver cannot stall and must take it then.
// An insert into a full queue reports status full, a remove from an empty queue
// reports status empty; neither changes the contents. held_o is the count after
// the transaction, kept to four bits.

module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = SpqDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     action_i,
  input  wire logic signed [ValueW-1:0] value_i,
  output logic                          result_valid_o,
  output logic [StatusW-1:0]            status_o,
  output logic signed [ValueW-1:0]      removed_value_o,
  output logic [HeldW-1:0]              held_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept, full, empty;
  cmd_t            cmd;

  logic signed [ValueW-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]         cell_lt;

  logic                     result_valid_q;
  logic [StatusW-1:0]       status_q, status_d;
  logic signed [ValueW-1:0] removed_q, removed_d;
  logic [CntW+HeldW-1:0]    count_ext;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  assign cmd.ins = accept & (action_i == ACT_INSERT) & ~full;
  assign cmd.rem = accept & (action_i == ACT_REMOVE) & ~empty;
  assign cmd.key = value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_lt;
    logic signed [ValueW-1:0] left_value, right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = value_i;
    end else begin : g_mid
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (CntW'(i) < count_q),
      .left_lt_i     (left_lt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .lt_o          (cell_lt[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    status_d  = STATUS_DONE;
    removed_d = '0;
    if (accept) begin
      if (action_i == ACT_INSERT) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          count_d   = count_q - CntW'(1);
          removed_d = cell_value[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      result_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign count_ext       = {{HeldW{1'b0}}, count_q};
  assign result_valid_o  = result_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign held_o          = count_ext[HeldW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy above DEPTH");

  a_result_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted transaction gave no result");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_INSERT && full) |=>
      (status_o == STATUS_FULL && $stable(count_q)))
    else $error("insert into full queue not rejected");

  a_empty_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_REMOVE && empty) |=>
      (status_o == STATUS_EMPTY && removed_value_o == '0 && count_q == '0))
    else $error("remove from empty queue not reported");

endmodule

`default_nettype wire

@@ design/spq_cell.sv @@
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire cmd_t                     cmd_i,
  input  wire logic                     occ_i,
  input  wire logic                     left_lt_i,
  input  wire logic signed [ValueW-1:0] left_value_i,
  input  wire logic signed [ValueW-1:0] right_value_i,
  output logic signed [ValueW-1:0]      value_o,
  output logic                          lt_o
);

  logic signed [ValueW-1:0] value_q, value_d;

  // held value is strictly below the key: the new one goes further right
  assign lt_o    = occ_i & (value_q < cmd_i.key);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins && !lt_o) begin
      value_d = left_lt_i ? cmd_i.key : left_value_i;
    end else if (cmd_i.rem) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire
